FILE: src/apt_pkg.sv
// shared types and constants of the affine point transform
`timescale 1ns / 1ps
`default_nettype none

package apt_pkg;

  localparam int COORD_W   = 32;
  localparam int CFG_W     = 64;
  localparam int NUM_REGS  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_LANES = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [CFG_W-1:0]          coef_word_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

  // register indexes
  localparam cfg_idx_t REG_ROW0_COLS01 = 3'd0;
  localparam cfg_idx_t REG_ROW0_COLS23 = 3'd1;
  localparam cfg_idx_t REG_ROW1_COLS01 = 3'd2;
  localparam cfg_idx_t REG_ROW1_COLS23 = 3'd3;
  localparam cfg_idx_t REG_ROW2_COLS01 = 3'd4;
  localparam cfg_idx_t REG_ROW2_COLS23 = 3'd5;

  // identity matrix in Q16.16
  localparam coef_word_t RST_ROW0_COLS01 = 64'h0000_0000_0001_0000;
  localparam coef_word_t RST_ROW0_COLS23 = 64'h0000_0000_0000_0000;
  localparam coef_word_t RST_ROW1_COLS01 = 64'h0001_0000_0000_0000;
  localparam coef_word_t RST_ROW1_COLS23 = 64'h0000_0000_0000_0000;
  localparam coef_word_t RST_ROW2_COLS01 = 64'h0000_0000_0000_0000;
  localparam coef_word_t RST_ROW2_COLS23 = 64'h0000_0000_0001_0000;

  localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    coord_t value;
    logic   sat;
  } lane_res_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   sat;
  } item_t;

endpackage

`default_nettype wire

FILE: src/apt_if.sv
// valid/ready channel interfaces for points in and transformed points out
`timescale 1ns / 1ps
`default_nettype none

interface apt_in_if import apt_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t in_x;
  coord_t in_y;
  coord_t in_z;

  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface apt_out_if import apt_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic   saturated;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output saturated, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input saturated, output ready);
endinterface

`default_nettype wire

FILE: src/apt_lane.sv
// one matrix row: multiply, exact sum, floor shift and saturation over three stages
`timescale 1ns / 1ps
`default_nettype none

module apt_lane import apt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       en,
  input  wire coef_word_t cols01,
  input  wire coef_word_t cols23,
  input  wire coord_t     pt_x,
  input  wire coord_t     pt_y,
  input  wire coord_t     pt_z,
  output lane_res_t       res
);

  localparam int PROD_W = 2 * COORD_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int TOP_LO = FRAC_BITS + COORD_W - 1;

  logic signed [PROD_W-1:0] prod0_r, prod1_r, prod2_r;
  coord_t                   trans_r;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  lane_res_t                res_r, res_nxt;
  logic [SUM_W-TOP_LO-1:0]  top_bits;
  logic                     fits;

  // stage 1: the three products and the translation
  always_ff @(posedge clk) begin
    if (en) begin
      prod0_r <= $signed(cols01[COORD_W-1:0]) * pt_x;
      prod1_r <= $signed(cols01[CFG_W-1:COORD_W]) * pt_y;
      prod2_r <= $signed(cols23[COORD_W-1:0]) * pt_z;
      trans_r <= $signed(cols23[CFG_W-1:COORD_W]);
    end
  end

  // stage 2: exact sum, no bits dropped
  always_comb begin
    sum_nxt = SUM_W'(prod0_r) + SUM_W'(prod1_r) + SUM_W'(prod2_r)
            + (SUM_W'(trans_r) <<< FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

  // stage 3: dropping the fraction bits is a floor; clamp if the top bits disagree
  always_comb begin
    top_bits = sum_r[SUM_W-1:TOP_LO];
    fits     = (&top_bits) | (~|top_bits);
    if (fits) begin
      res_nxt.value = sum_r[TOP_LO:FRAC_BITS];
      res_nxt.sat   = 1'b0;
    end else begin
      res_nxt.value = sum_r[SUM_W-1] ? COORD_MIN : COORD_MAX;
      res_nxt.sat   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

FILE: src/apt_merge.sv
// joins the lane results into one transaction, with output register and skid stage
`timescale 1ns / 1ps
`default_nettype none

module apt_merge import apt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      res_valid,
  input  wire lane_res_t res [NUM_LANES],
  output logic           ready,
  apt_out_if.source      out_ch
);

  logic  out_valid_r, out_valid_nxt;
  logic  skid_valid_r, skid_valid_nxt;
  item_t out_item_r, out_item_nxt;
  item_t skid_item_r, skid_item_nxt;
  item_t merged;
  logic  take;

  always_comb begin
    merged.x   = res[0].value;
    merged.y   = res[1].value;
    merged.z   = res[2].value;
    merged.sat = res[0].sat | res[1].sat | res[2].sat;
  end

  // pipeline only moves while the skid stage is empty
  assign ready = !skid_valid_r;
  assign take  = res_valid && ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_item_nxt   = out_item_r;
    skid_item_nxt  = skid_item_r;
    if (out_valid_r && !out_ch.ready) begin
      if (take) begin
        skid_valid_nxt = 1'b1;
        skid_item_nxt  = merged;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_item_nxt   = skid_item_r;
      skid_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = take;
      out_item_nxt  = merged;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_x     = out_item_r.x;
  assign out_ch.out_y     = out_item_r.y;
  assign out_ch.out_z     = out_item_r.z;
  assign out_ch.saturated = out_item_r.sat;

endmodule

`default_nettype wire

FILE: src/affine_point_transform.sv
// affine point transform: three matrix rows in parallel lanes, merged per point
// throughput: one point per clock while the output is not stalled
// path: a point taken from the input passes the multiply, sum and saturate registers in the
//   lanes, then the output register
// reset: coefficients return to the identity matrix, pipeline and skid stage empty
`timescale 1ns / 1ps
`default_nettype none

module affine_point_transform import apt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire cfg_idx_t   cfg_index,
  input  wire coef_word_t cfg_wdata,
  apt_in_if.sink          in_ch,
  apt_out_if.source       out_ch
);

  coef_word_t coef_r   [NUM_REGS];
  coef_word_t coef_nxt [NUM_REGS];
  logic       v1_r, v2_r, v3_r;
  logic       merge_ready;
  logic       accept;
  lane_res_t  lane_res [NUM_LANES];

  // coefficient registers
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      coef_nxt[i] = coef_r[i];
    end
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROW0_COLS01: coef_nxt[0] = cfg_wdata;
        REG_ROW0_COLS23: coef_nxt[1] = cfg_wdata;
        REG_ROW1_COLS01: coef_nxt[2] = cfg_wdata;
        REG_ROW1_COLS23: coef_nxt[3] = cfg_wdata;
        REG_ROW2_COLS01: coef_nxt[4] = cfg_wdata;
        REG_ROW2_COLS23: coef_nxt[5] = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= RST_ROW0_COLS01;
      coef_r[1] <= RST_ROW0_COLS23;
      coef_r[2] <= RST_ROW1_COLS01;
      coef_r[3] <= RST_ROW1_COLS23;
      coef_r[4] <= RST_ROW2_COLS01;
      coef_r[5] <= RST_ROW2_COLS23;
    end else begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_r[i] <= coef_nxt[i];
      end
    end
  end

  assign in_ch.ready = merge_ready;
  assign accept      = in_ch.valid && merge_ready;

  // valid bits that travel alongside the lane stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (merge_ready) begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  for (genvar r = 0; r < NUM_LANES; r++) begin : g_lane
    apt_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .en     (merge_ready),
      .cols01 (coef_r[2*r]),
      .cols23 (coef_r[2*r+1]),
      .pt_x   (in_ch.in_x),
      .pt_y   (in_ch.in_y),
      .pt_z   (in_ch.in_z),
      .res    (lane_res[r])
    );
  end

  apt_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (v3_r),
    .res       (lane_res),
    .ready     (merge_ready),
    .out_ch    (out_ch)
  );

  // a full skid stage only exists behind a held output
  a_skid_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
    !merge_ready |-> out_ch.valid)
    else $error("skid stage full while output register empty");

  // a clamp flag must come with a coordinate at a range limit
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |->
      (out_ch.out_x == COORD_MAX || out_ch.out_x == COORD_MIN ||
       out_ch.out_y == COORD_MAX || out_ch.out_y == COORD_MIN ||
       out_ch.out_z == COORD_MAX || out_ch.out_z == COORD_MIN))
    else $error("saturated flag without a clamped coordinate");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> v1_r)
    else $error("accepted transaction did not enter the lanes");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && merge_ready |=> out_ch.valid)
    else $error("lane result lost at the merge");

endmodule

`default_nettype wire
